FILE: rtl/dscp_pkg.sv
package dscp_pkg;

    localparam int UID_BYTES     = 10;
    localparam int UID_W         = 8 * UID_BYTES;
    localparam int MAX_UID_BYTES = 10;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_READER_ENABLED  = 3'd0,
        REG_ENGAGE_DEBOUNCE = 3'd1,
        REG_RELEASE_DEBOUNCE = 3'd2,
        REG_BASE_POLL       = 3'd3,
        REG_WATCHDOG        = 3'd4
    } reg_addr_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_NEW    = 2'd1,
        EV_DETACH = 2'd2
    } card_ev_t;

    localparam logic FUNC_TICK     = 1'b0;
    localparam logic FUNC_RESPONSE = 1'b1;

    // reset values of the configuration registers
    localparam logic [15:0] ENGAGE_RST   = 16'd50;
    localparam logic [15:0] RELEASE_RST  = 16'd200;
    localparam logic [15:0] BASE_POLL_RST = 16'd100;
    localparam logic [19:0] WATCHDOG_RST = 20'd10000;

    // poll backoff tiers
    localparam logic [7:0]  FAIL_TIER1 = 8'd10;
    localparam logic [7:0]  FAIL_TIER2 = 8'd20;
    localparam logic [7:0]  FAIL_TIER3 = 8'd50;
    localparam logic [15:0] INTERVAL_TIER1 = 16'd200;
    localparam logic [15:0] INTERVAL_TIER2 = 16'd300;
    localparam logic [15:0] INTERVAL_TIER3 = 16'd500;

    typedef struct packed {
        logic        func;
        logic        contact_level;
        logic        read_ok;
        logic [7:0]  uid_len;
        logic [63:0] uid_low;
        logic [15:0] uid_high;
    } item_t;

    typedef struct packed {
        logic        poll_request;
        logic [1:0]  card_event;
        logic        session_open;
        logic        card_present;
        logic [3:0]  card_uid_len;
        logic [63:0] card_uid_low;
        logic [15:0] card_uid_high;
        logic [7:0]  failure_count;
        logic        watchdog_fired;
        logic        uid_too_long;
    } result_t;

    typedef struct packed {
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] wdata;
    } cfg_wr_t;

    typedef struct packed {
        logic        reader_enabled;
        logic [15:0] engage_debounce_ticks;
        logic [15:0] release_debounce_ticks;
        logic [15:0] base_poll_interval;
        logic [19:0] watchdog_ticks;
        logic        enable_rise;
    } cfg_t;

endpackage

FILE: rtl/dscp_item_if.sv
interface dscp_item_if;
    import dscp_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/dscp_result_if.sv
interface dscp_result_if;
    import dscp_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/dscp_cfg_if.sv
interface dscp_cfg_if;
    import dscp_pkg::*;

    logic    valid;
    logic    ready;
    cfg_wr_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/dock_session_card_poller_core.sv
// Channel   Role   Payload
// item      sink   func, contact_level, read_ok, uid_len, uid_low, uid_high
// result    source poll_request .. uid_too_long, one per item
// cfg       sink   addr (register index), wdata; always ready
//
// One item per cycle sustained while the result side is ready. An accepted item
// is held in the input register, is processed against the session state, and
// its result lands in the result register, which drives result valid.
// Reset clears all control and session state and loads register defaults.
// A stalled result register holds the input register; the input takes a new
// transfer in the same cycle the held one moves on.
module dock_session_card_poller_core (
    input logic         clk,
    input logic         rst_n,
    dscp_item_if.sink   item,
    dscp_result_if.source result,
    dscp_cfg_if.sink    cfg
);
    import dscp_pkg::*;

    logic    in_valid_reg;
    item_t   in_data_reg;
    logic    res_valid_reg;
    result_t res_data_reg;
    logic    fire;
    logic    res_free;
    cfg_t    cfg_vals;
    result_t eng_res;

    assign res_free   = !res_valid_reg || result.ready;
    assign fire       = in_valid_reg && res_free;
    assign item.ready = !in_valid_reg || fire;
    assign cfg.ready  = 1'b1;

    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

    dscp_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg.valid && cfg.ready),
        .wr    (cfg.data),
        .cfg   (cfg_vals)
    );

    dscp_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_vals),
        .fire  (fire),
        .item  (in_data_reg),
        .res   (eng_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.valid && item.ready)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;

            if (fire)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            in_data_reg <= item.data;
        if (fire)
            res_data_reg <= eng_res;
    end

`ifndef SYNTH
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_data_reg))
        else $error("input register lost a waiting item");

    a_new_card_open: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_data_reg.card_event == EV_NEW
        |-> res_data_reg.card_present && res_data_reg.session_open)
        else $error("new card reported outside an open session");

    a_poll_open: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_data_reg.poll_request
        |-> res_data_reg.session_open && res_data_reg.card_event == EV_NONE)
        else $error("poll requested with session closed or card event");

    a_uid_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_data_reg.card_uid_len <= 4'(MAX_UID_BYTES))
        else $error("latched UID length above maximum");
`endif
endmodule

FILE: rtl/dscp_cfg_regs.sv
module dscp_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  dscp_pkg::cfg_wr_t wr,
    output dscp_pkg::cfg_t    cfg
);
    import dscp_pkg::*;

    logic        enabled_reg;
    logic [15:0] engage_reg;
    logic [15:0] release_reg;
    logic [15:0] base_poll_reg;
    logic [19:0] watchdog_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            engage_reg    <= ENGAGE_RST;
            release_reg   <= RELEASE_RST;
            base_poll_reg <= BASE_POLL_RST;
            watchdog_reg  <= WATCHDOG_RST;
        end
        else if (wr_en)
        begin
            case (wr.addr)
                REG_READER_ENABLED:   enabled_reg   <= wr.wdata[0];
                REG_ENGAGE_DEBOUNCE:  engage_reg    <= wr.wdata[15:0];
                REG_RELEASE_DEBOUNCE: release_reg   <= wr.wdata[15:0];
                REG_BASE_POLL:        base_poll_reg <= wr.wdata[15:0];
                REG_WATCHDOG:         watchdog_reg  <= wr.wdata[19:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        cfg.reader_enabled         = enabled_reg;
        cfg.engage_debounce_ticks  = engage_reg;
        cfg.release_debounce_ticks = release_reg;
        cfg.base_poll_interval     = base_poll_reg;
        cfg.watchdog_ticks         = watchdog_reg;
        // off-to-on write restarts failure tracking
        cfg.enable_rise = wr_en && (wr.addr == REG_READER_ENABLED)
                          && wr.wdata[0] && !enabled_reg;
    end
endmodule

FILE: rtl/dscp_engine.sv
module dscp_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  dscp_pkg::cfg_t    cfg,
    input  logic              fire,
    input  dscp_pkg::item_t   item,
    output dscp_pkg::result_t res
);
    import dscp_pkg::*;

    logic             pending_reg, pending_next;
    logic [15:0]      stable_reg, stable_next;
    logic             session_reg, session_next;
    logic             card_seen_reg, card_seen_next;
    logic             read_in_sess_reg, read_in_sess_next;
    logic [15:0]      since_attempt_reg, since_attempt_next;
    logic [19:0]      since_success_reg, since_success_next;
    logic [7:0]       fail_reg, fail_next;
    logic             awaiting_reg, awaiting_next;
    logic [UID_W-1:0] prev_uid_reg, prev_uid_next;
    logic [3:0]       prev_len_reg, prev_len_next;
    logic [UID_W-1:0] held_uid_reg, held_uid_next;
    logic [3:0]       held_len_reg, held_len_next;
    logic             held_valid_reg, held_valid_next;

    logic [UID_W-1:0] uid_raw;
    logic [UID_W-1:0] uid_masked;
    logic [15:0]      threshold;
    logic             settle;
    logic             poll;
    logic             wd_fired;
    logic             too_long;
    card_ev_t         event_code;

    function automatic logic [15:0] poll_interval(input logic [7:0] fails,
                                                  input logic [15:0] base);
        if (fails > FAIL_TIER3)
            return INTERVAL_TIER3;
        else if (fails > FAIL_TIER2)
            return INTERVAL_TIER2;
        else if (fails > FAIL_TIER1)
            return INTERVAL_TIER1;
        else
            return base;
    endfunction

    always_comb
    begin
        uid_raw = {item.uid_high, item.uid_low};
        for (int i = 0; i < UID_BYTES; i++)
        begin
            uid_masked[8*i +: 8] = (item.uid_len > 8'(i)) ? uid_raw[8*i +: 8] : 8'd0;
        end

        pending_next       = pending_reg;
        stable_next        = stable_reg;
        session_next       = session_reg;
        card_seen_next     = card_seen_reg;
        read_in_sess_next  = read_in_sess_reg;
        since_attempt_next = since_attempt_reg;
        since_success_next = since_success_reg;
        fail_next          = fail_reg;
        awaiting_next      = awaiting_reg;
        prev_uid_next      = prev_uid_reg;
        prev_len_next      = prev_len_reg;
        held_uid_next      = held_uid_reg;
        held_len_next      = held_len_reg;
        held_valid_next    = held_valid_reg;
        threshold          = 16'd0;
        settle             = 1'b0;
        poll               = 1'b0;
        wd_fired           = 1'b0;
        too_long           = 1'b0;
        event_code         = EV_NONE;

        if (cfg.reader_enabled)
        begin
            if (item.func == FUNC_TICK)
            begin
                since_attempt_next = (since_attempt_reg == '1) ? since_attempt_reg
                                                               : since_attempt_reg + 16'd1;
                since_success_next = (since_success_reg == '1) ? since_success_reg
                                                               : since_success_reg + 20'd1;
                if (item.contact_level != pending_reg)
                begin
                    pending_next = item.contact_level;
                    stable_next  = 16'd0;
                end
                else
                begin
                    stable_next = (stable_reg == '1) ? stable_reg : stable_reg + 16'd1;
                end

                threshold = pending_next ? cfg.engage_debounce_ticks
                                         : cfg.release_debounce_ticks;
                settle = (stable_next > threshold) && (pending_next != session_reg);
                if (settle)
                begin
                    session_next  = pending_next;
                    awaiting_next = 1'b0;
                    if (pending_next)
                    begin
                        read_in_sess_next = 1'b0;
                        prev_uid_next     = '0;
                        prev_len_next     = 4'd0;
                        fail_next         = 8'd0;
                    end
                    else
                    begin
                        if (read_in_sess_reg)
                            event_code = EV_DETACH;
                        card_seen_next    = 1'b0;
                        read_in_sess_next = 1'b0;
                        held_valid_next   = 1'b0;
                    end
                end

                if (session_next && !read_in_sess_next && !awaiting_next
                    && since_attempt_next >= poll_interval(fail_next, cfg.base_poll_interval))
                begin
                    if (since_success_next > cfg.watchdog_ticks)
                    begin
                        fail_next          = 8'd0;
                        since_success_next = 20'd0;
                        wd_fired           = 1'b1;
                    end
                    since_attempt_next = 16'd0;
                    awaiting_next      = 1'b1;
                    poll               = 1'b1;
                end
            end
            else if (awaiting_reg)
            begin
                awaiting_next = 1'b0;
                if (item.read_ok)
                begin
                    card_seen_next     = 1'b1;
                    fail_next          = 8'd0;
                    since_success_next = {4'd0, since_attempt_reg};
                    if (item.uid_len > 8'(MAX_UID_BYTES))
                    begin
                        too_long = 1'b1;
                    end
                    else if (item.uid_len[3:0] != prev_len_reg || uid_masked != prev_uid_reg)
                    begin
                        prev_uid_next     = uid_masked;
                        prev_len_next     = item.uid_len[3:0];
                        read_in_sess_next = 1'b1;
                        held_uid_next     = uid_masked;
                        held_len_next     = item.uid_len[3:0];
                        held_valid_next   = 1'b1;
                        event_code        = EV_NEW;
                    end
                end
                else
                begin
                    fail_next = (fail_reg == '1) ? fail_reg : fail_reg + 8'd1;
                end
            end
        end

        res.poll_request   = poll;
        res.card_event     = event_code;
        res.session_open   = session_next;
        res.card_present   = card_seen_next && session_next;
        res.card_uid_len   = held_valid_next ? held_len_next : 4'd0;
        res.card_uid_low   = held_valid_next ? held_uid_next[63:0] : 64'd0;
        res.card_uid_high  = held_valid_next ? held_uid_next[79:64] : 16'd0;
        res.failure_count  = fail_next;
        res.watchdog_fired = wd_fired;
        res.uid_too_long   = too_long;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg       <= 1'b0;
            stable_reg        <= 16'd0;
            session_reg       <= 1'b0;
            card_seen_reg     <= 1'b0;
            read_in_sess_reg  <= 1'b0;
            since_attempt_reg <= 16'd0;
            since_success_reg <= 20'd0;
            fail_reg          <= 8'd0;
            awaiting_reg      <= 1'b0;
            prev_uid_reg      <= '0;
            prev_len_reg      <= 4'd0;
            held_uid_reg      <= '0;
            held_len_reg      <= 4'd0;
            held_valid_reg    <= 1'b0;
        end
        else if (cfg.enable_rise)
        begin
            fail_reg          <= 8'd0;
            since_success_reg <= 20'd0;
        end
        else if (fire)
        begin
            pending_reg       <= pending_next;
            stable_reg        <= stable_next;
            session_reg       <= session_next;
            card_seen_reg     <= card_seen_next;
            read_in_sess_reg  <= read_in_sess_next;
            since_attempt_reg <= since_attempt_next;
            since_success_reg <= since_success_next;
            fail_reg          <= fail_next;
            awaiting_reg      <= awaiting_next;
            prev_uid_reg      <= prev_uid_next;
            prev_len_reg      <= prev_len_next;
            held_uid_reg      <= held_uid_next;
            held_len_reg      <= held_len_next;
            held_valid_reg    <= held_valid_next;
        end
    end
endmodule

FILE: tb/sv/dock_session_card_poller_core_tb.sv
`timescale 1ns / 1ps

module dock_session_card_poller_core_tb;
    import dscp_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 25;

    logic clk = 1'b0;
    logic rst_n;

    dscp_item_if   item_if();
    dscp_result_if res_if();
    dscp_cfg_if    cfg_if();

    dock_session_card_poller_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    // results the block still owes, oldest first
    result_t results_due[$];
    int      err_count = 0;
    int      cycle_no = 0;
    int      src_idle = 34;
    int      snk_idle = 57;
    int      hold_off = 0;
    logic    contact_goal = 1'b0;

    // shadow registers
    logic        en = 1'b0;
    logic [15:0] eng_dly = ENGAGE_RST;
    logic [15:0] rel_dly = RELEASE_RST;
    logic [15:0] base_ivl = BASE_POLL_RST;
    logic [19:0] wd_lim = WATCHDOG_RST;

    // shadow session state
    logic        lvl_pend = 1'b0;
    logic [15:0] stable_cnt = '0;
    logic        sess = 1'b0;
    logic        seen = 1'b0;
    logic        read_in_sess = 1'b0;
    logic [15:0] since_poll = '0;
    logic [19:0] since_ok = '0;
    logic [7:0]  fails = '0;
    logic        waiting = 1'b0;
    logic [79:0] last_uid = '0;
    logic [3:0]  last_len = '0;
    logic [79:0] held_uid = '0;
    logic [3:0]  held_len = '0;
    logic        held_vld = 1'b0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin : cycle_limit
        while (cycle_no < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_no++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [15:0] backoff_interval();
        if (fails > FAIL_TIER3)
            return INTERVAL_TIER3;
        if (fails > FAIL_TIER2)
            return INTERVAL_TIER2;
        if (fails > FAIL_TIER1)
            return INTERVAL_TIER1;
        return base_ivl;
    endfunction

    function automatic void apply_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_READER_ENABLED:
            begin
                if (val[0] && !en)
                begin
                    fails = '0;
                    since_ok = '0;
                end
                en = val[0];
            end
            REG_ENGAGE_DEBOUNCE:  eng_dly = val[15:0];
            REG_RELEASE_DEBOUNCE: rel_dly = val[15:0];
            REG_BASE_POLL:        base_ivl = val[15:0];
            REG_WATCHDOG:         wd_lim = val[19:0];
            default: ;
        endcase
    endfunction

    // advances the shadow state by one item and returns the result it owes
    function automatic result_t poller_next(item_t it);
        result_t     r;
        logic [63:0] lo_mask;
        logic [15:0] hi_mask;
        logic [79:0] uid;
        r = '0;
        if (en)
        begin
            if (it.func == FUNC_TICK)
            begin
                if (since_poll != 16'hFFFF)
                    since_poll++;
                if (since_ok != 20'hFFFFF)
                    since_ok++;
                if (it.contact_level != lvl_pend)
                begin
                    lvl_pend = it.contact_level;
                    stable_cnt = '0;
                end
                else if (stable_cnt != 16'hFFFF)
                    stable_cnt++;
                if (stable_cnt > (lvl_pend ? eng_dly : rel_dly) && lvl_pend != sess)
                begin
                    sess = lvl_pend;
                    waiting = 1'b0;
                    if (sess)
                    begin
                        read_in_sess = 1'b0;
                        last_uid = '0;
                        last_len = '0;
                        fails = '0;
                    end
                    else
                    begin
                        if (read_in_sess)
                            r.card_event = EV_DETACH;
                        seen = 1'b0;
                        read_in_sess = 1'b0;
                        held_vld = 1'b0;
                    end
                end
                if (sess && !read_in_sess && !waiting && since_poll >= backoff_interval())
                begin
                    if (since_ok > wd_lim)
                    begin
                        fails = '0;
                        since_ok = '0;
                        r.watchdog_fired = 1'b1;
                    end
                    since_poll = '0;
                    waiting = 1'b1;
                    r.poll_request = 1'b1;
                end
            end
            else if (waiting)
            begin
                waiting = 1'b0;
                if (it.read_ok)
                begin
                    seen = 1'b1;
                    fails = '0;
                    since_ok = {4'b0, since_poll};
                    if (it.uid_len > MAX_UID_BYTES)
                        r.uid_too_long = 1'b1;
                    else
                    begin
                        lo_mask = (it.uid_len >= 8) ? '1 : ((64'd1 << (8 * it.uid_len)) - 64'd1);
                        hi_mask = (it.uid_len >= 10) ? 16'hFFFF :
                                  (it.uid_len == 9) ? 16'h00FF : 16'h0000;
                        uid = {it.uid_high & hi_mask, it.uid_low & lo_mask};
                        if (it.uid_len[3:0] != last_len || uid != last_uid)
                        begin
                            last_uid = uid;
                            last_len = it.uid_len[3:0];
                            read_in_sess = 1'b1;
                            held_uid = uid;
                            held_len = it.uid_len[3:0];
                            held_vld = 1'b1;
                            r.card_event = EV_NEW;
                        end
                    end
                end
                else if (fails != 8'hFF)
                    fails++;
            end
        end
        r.session_open  = sess;
        r.card_present  = seen && sess;
        r.card_uid_len  = held_vld ? held_len : 4'd0;
        r.card_uid_low  = held_vld ? held_uid[63:0] : 64'd0;
        r.card_uid_high = held_vld ? held_uid[79:64] : 16'd0;
        r.failure_count = fails;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [79:0] got, logic [79:0] want);
        err_count++;
        $display("[cycle %0d] %s: got 0x%0h, expected 0x%0h", cycle_no, what, got, want);
    endtask

    task automatic check_fields(result_t got, result_t want);
        if (got.poll_request !== want.poll_request)
            report_mismatch("poll_request", got.poll_request, want.poll_request);
        if (got.card_event !== want.card_event)
            report_mismatch("card_event", got.card_event, want.card_event);
        if (got.session_open !== want.session_open)
            report_mismatch("session_open", got.session_open, want.session_open);
        if (got.card_present !== want.card_present)
            report_mismatch("card_present", got.card_present, want.card_present);
        if (got.card_uid_len !== want.card_uid_len)
            report_mismatch("card_uid_len", got.card_uid_len, want.card_uid_len);
        if (got.card_uid_low !== want.card_uid_low)
            report_mismatch("card_uid_low", got.card_uid_low, want.card_uid_low);
        if (got.card_uid_high !== want.card_uid_high)
            report_mismatch("card_uid_high", got.card_uid_high, want.card_uid_high);
        if (got.failure_count !== want.failure_count)
            report_mismatch("failure_count", got.failure_count, want.failure_count);
        if (got.watchdog_fired !== want.watchdog_fired)
            report_mismatch("watchdog_fired", got.watchdog_fired, want.watchdog_fired);
        if (got.uid_too_long !== want.uid_too_long)
            report_mismatch("uid_too_long", got.uid_too_long, want.uid_too_long);
    endtask

    initial
    begin : result_checker
        result_t got;
        forever
        begin
            @(posedge clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
            begin
                got = res_if.data;
                if (results_due.size() == 0)
                    report_mismatch("result transfer with nothing expected", '0, '0);
                else
                    check_fields(got, results_due.pop_front());
            end
        end
    end

    // result side pacing; a hold-off forces ready low until it has counted down to zero
    initial
    begin : sink_pacing
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                res_if.ready = 1'b0;
            end
            else
                res_if.ready = ($urandom_range(99) >= snk_idle);
        end
    end

    task automatic set_idling(int mode);
        case (mode)
            0:
            begin
                src_idle = 34;
                snk_idle = 57;
            end
            1:
            begin
                src_idle = 57;
                snk_idle = 34;
            end
            default:
            begin
                src_idle = 0;
                snk_idle = 0;
            end
        endcase
    endtask

    task automatic send_item(item_t it);
        @(negedge clk);
        while ($urandom_range(99) < src_idle)
        begin
            item_if.valid = 1'b0;
            @(negedge clk);
        end
        item_if.valid = 1'b1;
        item_if.data  = it;
        do
            @(posedge clk);
        while (item_if.ready !== 1'b1);
        results_due.push_back(poller_next(it));
    endtask

    // stop offering items and wait for every owed result
    task automatic drain();
        @(negedge clk);
        item_if.valid = 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_if.valid      = 1'b1;
        cfg_if.data.addr  = idx;
        cfg_if.data.wdata = val;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        apply_reg(idx, val);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic item_t tick_item(logic lvl);
        item_t it;
        it.func          = FUNC_TICK;
        it.contact_level = lvl;
        it.read_ok       = 1'($urandom);
        it.uid_len       = 8'($urandom);
        it.uid_low       = {$urandom, $urandom};
        it.uid_high      = 16'($urandom);
        return it;
    endfunction

    function automatic item_t resp_item(logic ok, logic [7:0] len, logic [63:0] lo,
                                        logic [15:0] hi);
        item_t it;
        it.func          = FUNC_RESPONSE;
        it.contact_level = 1'($urandom);
        it.read_ok       = ok;
        it.uid_len       = len;
        it.uid_low       = lo;
        it.uid_high      = hi;
        return it;
    endfunction

    function automatic item_t random_response();
        int         p;
        logic [7:0] len;
        p = $urandom_range(99);
        if (p < 70)
            len = 8'($urandom_range(MAX_UID_BYTES));
        else if (p < 85)
            len = 8'(MAX_UID_BYTES);
        else
            len = 8'($urandom_range(255, MAX_UID_BYTES + 1));
        return resp_item(1'($urandom_range(99) < 55), len, {$urandom, $urandom},
                         16'($urandom));
    endfunction

    task automatic send_ticks(int n, logic lvl);
        repeat (n)
            send_item(tick_item(lvl));
    endtask

    task automatic tick_until_poll(logic lvl);
        int tries;
        tries = 0;
        while (!waiting && tries < 70000)
        begin
            send_item(tick_item(lvl));
            tries++;
        end
    endtask

    // contact wanders between levels with some bounce; polls mostly get answers
    task automatic random_traffic(int n);
        int k;
        for (k = 0; k < n; k++)
        begin
            if (waiting && $urandom_range(99) < 75)
                send_item(random_response());
            else if ($urandom_range(99) < 4)
                send_item(random_response());
            else
            begin
                if ($urandom_range(99) < 3)
                    contact_goal = !contact_goal;
                send_item(tick_item(($urandom_range(99) < 8) ? !contact_goal : contact_goal));
            end
        end
    endtask

    task automatic random_config(bit extremes);
        logic [15:0] eng;
        logic [15:0] rel;
        logic [15:0] ivl;
        logic [19:0] wd;
        if (extremes)
        begin
            eng = 16'd0;
            rel = 16'hFFFF;
            ivl = 16'd1;
            wd  = 20'd1;
        end
        else
        begin
            eng = ($urandom_range(99) < 85) ? 16'($urandom_range(6))
                                            : 16'($urandom_range(40, 20));
            rel = ($urandom_range(99) < 90) ? 16'($urandom_range(6))
                                            : 16'($urandom_range(30, 10));
            ivl = ($urandom_range(99) < 80) ? 16'($urandom_range(6, 1))
                                            : 16'($urandom_range(60, 20));
            case ($urandom_range(2))
                0:       wd = 20'($urandom_range(5, 1));
                1:       wd = 20'($urandom_range(60, 6));
                default: wd = 20'hFFFFF;
            endcase
        end
        drain();
        write_reg(REG_ENGAGE_DEBOUNCE, {4'($urandom), eng});
        write_reg(REG_RELEASE_DEBOUNCE, {4'($urandom), rel});
        write_reg(REG_BASE_POLL, {4'($urandom), ivl});
        write_reg(REG_WATCHDOG, wd);
        write_reg(REG_READER_ENABLED, {19'($urandom), 1'b1});
    endtask

    // items are ignored while disabled, then the reset register values govern
    task automatic test_reset_values();
        send_item(tick_item(1'b1));
        send_item(resp_item(1'b1, 8'd4, '1, '1));
        send_item(tick_item(1'b0));
        drain();
        write_reg(REG_WATCHDOG + 3'($urandom_range(3, 1)), 20'($urandom));
        write_reg(REG_READER_ENABLED, 20'd1);
        // opens after the default engage delay, polls at the default interval
        send_ticks(101, 1'b1);
        send_item(resp_item(1'b0, 8'd0, '0, '0));
        send_ticks(20, 1'b0);
    endtask

    task automatic test_directed();
        set_idling(0);
        drain();
        write_reg(REG_ENGAGE_DEBOUNCE, 20'd1);
        write_reg(REG_RELEASE_DEBOUNCE, 20'd1);
        write_reg(REG_BASE_POLL, 20'd2);
        write_reg(REG_WATCHDOG, 20'd4);
        send_ticks(3, 1'b1);
        send_item(resp_item(1'b0, 8'd3, {$urandom, $urandom}, 16'($urandom)));
        tick_until_poll(1'b1);
        // zero-length UID matches the empty previous UID: success, no new card
        send_item(resp_item(1'b1, 8'd0, '1, '1));
        tick_until_poll(1'b1);
        send_item(resp_item(1'b1, 8'hFF, '1, '1));
        tick_until_poll(1'b1);
        send_item(resp_item(1'b1, 8'(MAX_UID_BYTES + 1), {$urandom, $urandom}, 16'($urandom)));
        tick_until_poll(1'b1);
        send_item(resp_item(1'b1, 8'(MAX_UID_BYTES), '1, '1));
        // stray response, nothing awaited
        send_item(resp_item(1'b1, 8'd3, {$urandom, $urandom}, 16'($urandom)));
        send_ticks(1, 1'b0);
        send_ticks(1, 1'b1);
        send_ticks(3, 1'b0);
        send_ticks(3, 1'b1);
        tick_until_poll(1'b1);
        // bytes past the length are dropped
        send_item(resp_item(1'b1, 8'd4, '1, '1));
        send_ticks(3, 1'b0);
    endtask

    task automatic test_backoff_tiers();
        drain();
        write_reg(REG_ENGAGE_DEBOUNCE, 20'd0);
        write_reg(REG_RELEASE_DEBOUNCE, 20'd0);
        write_reg(REG_BASE_POLL, 20'd1);
        write_reg(REG_WATCHDOG, 20'hFFFFF);
        send_ticks(2, 1'b0);
        while (fails <= FAIL_TIER1)
        begin
            tick_until_poll(1'b1);
            send_item(resp_item(1'b0, 8'($urandom), {$urandom, $urandom}, 16'($urandom)));
        end
        // one poll at the first backoff interval, then a success
        tick_until_poll(1'b1);
        send_item(resp_item(1'b1, 8'(MAX_UID_BYTES), {$urandom, $urandom}, 16'($urandom)));
    endtask

    // the longest engage delay keeps the session closed
    task automatic test_debounce_saturation();
        drain();
        write_reg(REG_RELEASE_DEBOUNCE, 20'd0);
        send_ticks(2, 1'b0);
        drain();
        write_reg(REG_ENGAGE_DEBOUNCE, 20'hFFFF);
        write_reg(REG_BASE_POLL, 20'hFFFF);
        send_ticks(40, 1'b1);
        drain();
        write_reg(REG_ENGAGE_DEBOUNCE, 20'd0);
        send_ticks(1, 1'b1);
        send_item(resp_item(1'b1, 8'(MAX_UID_BYTES), {$urandom, $urandom}, 16'($urandom)));
        send_ticks(2, 1'b0);
    endtask

    task automatic test_output_stall();
        drain();
        write_reg(REG_ENGAGE_DEBOUNCE, 20'd2);
        write_reg(REG_RELEASE_DEBOUNCE, 20'd2);
        write_reg(REG_BASE_POLL, 20'd3);
        write_reg(REG_WATCHDOG, 20'd30);
        hold_off = 300;
        random_traffic(60);
        drain();
        random_traffic(20);
    endtask

    task automatic test_random_traffic();
        int mode;
        int ph;
        for (mode = 0; mode < 3; mode++)
        begin
            set_idling(mode);
            for (ph = 0; ph < 3; ph++)
            begin
                random_config(mode == 2 && ph == 0);
                random_traffic(PHASE_ITEMS);
            end
            // disabled stretch; turning the reader back on clears the failures
            drain();
            write_reg(REG_READER_ENABLED, {19'($urandom), 1'b0});
            random_traffic(15);
            drain();
            write_reg(REG_READER_ENABLED, {19'($urandom), 1'b1});
            random_traffic(20);
        end
    endtask

    initial
    begin
        item_if.valid = 1'b0;
        item_if.data  = '0;
        res_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        rst_n         = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_directed();
        test_backoff_tiers();
        test_debounce_saturation();
        test_output_stall();
        test_random_traffic();

        drain();
        // room for a stray transfer to show up
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/dscp_pkg.sv
rtl/dscp_item_if.sv
rtl/dscp_result_if.sv
rtl/dscp_cfg_if.sv
rtl/dscp_cfg_regs.sv
rtl/dscp_engine.sv
rtl/dock_session_card_poller_core.sv
tb/sv/dock_session_card_poller_core_tb.sv
